### rtl/core/tvs_pkg.sv
package tvs_pkg;

	localparam int DIM_X = 64;
	localparam int DIM_Y = 64;
	localparam int DIM_Z = 64;

	localparam int DIM_XY_MAX = (DIM_X > DIM_Y) ? DIM_X : DIM_Y;
	localparam int DIM_MAX = (DIM_XY_MAX > DIM_Z) ? DIM_XY_MAX : DIM_Z;
	// width of a cell index, enough for DIM-2 on every axis
	localparam int CW = $clog2(DIM_MAX);

	// per-axis index width inside one parity bank
	localparam int HXW = ($clog2((DIM_X + 1) / 2) > 0) ? $clog2((DIM_X + 1) / 2) : 1;
	localparam int HYW = ($clog2((DIM_Y + 1) / 2) > 0) ? $clog2((DIM_Y + 1) / 2) : 1;
	localparam int HZW = ($clog2((DIM_Z + 1) / 2) > 0) ? $clog2((DIM_Z + 1) / 2) : 1;
	localparam int BANK_AW = HXW + HYW + HZW;
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int NBANK = 8;

	localparam int QDEPTH = 4;
	localparam int QPW = $clog2(QDEPTH);

	localparam int CFG_AW = 5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_INV_SPACING_X = 3'd3;
	localparam logic [2:0] REG_INV_SPACING_Y = 3'd4;
	localparam logic [2:0] REG_INV_SPACING_Z = 3'd5;

	localparam logic [31:0] INV_SPACING_RESET = 32'h0001_0000;

	typedef struct packed {
		logic [31:0] origin_x;
		logic [31:0] origin_y;
		logic [31:0] origin_z;
		logic [31:0] inv_spacing_x;
		logic [31:0] inv_spacing_y;
		logic [31:0] inv_spacing_z;
	} tvs_cfg_t;

	typedef struct packed {
		logic        query;
		logic [5:0]  voxel_x;
		logic [5:0]  voxel_y;
		logic [5:0]  voxel_z;
		logic [15:0] voxel_value;
		logic [32:0] diff_x;
		logic [32:0] diff_y;
		logic [32:0] diff_z;
	} tvs_item_t;

endpackage

### rtl/core/tvs_ram.sv
module tvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/tvs_front.sv
module tvs_front import tvs_pkg::*; (
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             opcode,
	input  logic [5:0]       voxel_x,
	input  logic [5:0]       voxel_y,
	input  logic [5:0]       voxel_z,
	input  logic signed [15:0] voxel_value,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic signed [31:0] query_z,
	input  tvs_cfg_t         cfg,
	input  logic             q_full,
	output logic             push,
	output tvs_item_t        item
);

	logic in_grid;
	logic is_query;

	assign item_stall = q_full;
	assign is_query = (opcode == OP_QUERY);
	assign in_grid = (32'(voxel_x) < 32'(DIM_X)) && (32'(voxel_y) < 32'(DIM_Y))
		&& (32'(voxel_z) < 32'(DIM_Z));

	// writes outside the grid are dropped here and never reach the queue
	assign push = item_valid && !q_full && (is_query || in_grid);

	always_comb begin
		item.query = is_query;
		item.voxel_x = voxel_x;
		item.voxel_y = voxel_y;
		item.voxel_z = voxel_z;
		item.voxel_value = voxel_value;
		item.diff_x = 33'(query_x) - 33'($signed(cfg.origin_x));
		item.diff_y = 33'(query_y) - 33'($signed(cfg.origin_y));
		item.diff_z = 33'(query_z) - 33'($signed(cfg.origin_z));
	end

endmodule

### rtl/core/tvs_queue.sv
module tvs_queue import tvs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tvs_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output tvs_item_t head_item
);

	tvs_item_t        mem_q [QDEPTH];
	logic [QPW-1:0]   wr_q;
	logic [QPW-1:0]   rd_q;
	logic [QPW:0]     cnt_q;

	assign full = (cnt_q == (QPW + 1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/tvs_back.sv
module tvs_back import tvs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tvs_cfg_t           cfg,
	input  logic               head_valid,
	input  tvs_item_t          head_item,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] sample,
	output logic               clamped
);

	typedef struct packed {
		logic        query;
		logic [5:0]  voxel_x;
		logic [5:0]  voxel_y;
		logic [5:0]  voxel_z;
		logic [15:0] voxel_value;
	} tvs_wr_t;

	localparam logic [CW-1:0] CELL_MAX [3] = '{CW'(DIM_X - 2), CW'(DIM_Y - 2), CW'(DIM_Z - 2)};
	localparam logic signed [49:0] FX_HI = 50'sd8589934591;
	localparam logic signed [49:0] FX_LO = -50'sd8589934591;
	localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
	localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		priority if (v > SAT_HI) begin
			return SAT_HI[31:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[31:0];
		end else begin
			return v[31:0];
		end
	endfunction

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;

	logic signed [32:0] diff_w [3];
	logic [31:0]        inv_w [3];

	logic signed [49:0] pl_s1 [3];
	logic signed [49:0] ph_s1 [3];
	tvs_wr_t            wr_s1;

	logic signed [65:0] p_s2 [3];
	tvs_wr_t            wr_s2;

	logic signed [33:0] cell_w [3];
	logic signed [49:0] u_w [3];
	logic [CW-1:0]      c_w [3];
	logic signed [49:0] f_w [3];
	logic               cl_w;

	logic [CW-1:0]      cell_s3 [3];
	logic signed [49:0] f_s3 [3];
	logic               cl_s3;
	tvs_wr_t            wr_s3;

	logic [CW-1:0]      half_w [3][2];
	logic [BANK_AW-1:0] raddr_w [NBANK];
	logic [BANK_AW-1:0] waddr_w;
	logic [2:0]         wbank_w;
	logic               wr_en;
	logic [15:0]        rd_data [NBANK];

	logic [2:0]         par_s4;
	logic signed [49:0] fx_s4, fy_s4, fz_s4;
	logic               cl_s4;

	logic signed [15:0] va_w [4];
	logic signed [15:0] vb_w [4];
	logic signed [16:0] d1_w [4];
	logic signed [33:0] fxl_w;

	logic signed [50:0] m1_s5 [4];
	logic signed [15:0] va_s5 [4];
	logic signed [49:0] fy_s5, fz_s5;
	logic               cl_s5;

	logic signed [31:0] c1_s6 [4];
	logic signed [49:0] fy_s6, fz_s6;
	logic               cl_s6;

	logic signed [32:0] d2_w [2];
	logic signed [58:0] pl2_s7 [2];
	logic signed [57:0] ph2_s7 [2];
	logic signed [31:0] a2_s7 [2];
	logic signed [49:0] fz_s7;
	logic               cl_s7;

	logic signed [82:0] prod2_w [2];
	logic signed [66:0] x2_s8 [2];
	logic signed [31:0] a2_s8 [2];
	logic signed [49:0] fz_s8;
	logic               cl_s8;

	logic signed [31:0] c2_s9 [2];
	logic signed [49:0] fz_s9;
	logic               cl_s9;

	logic signed [32:0] d3_w;
	logic signed [58:0] pl3_s10;
	logic signed [57:0] ph3_s10;
	logic signed [31:0] a3_s10;
	logic               cl_s10;

	logic signed [82:0] prod3_w;
	logic signed [66:0] x3_s11;
	logic signed [31:0] a3_s11;
	logic               cl_s11;

	logic signed [31:0] sample_s12;
	logic               clamped_s12;

	// whole pipe moves together; the output register frees it when taken
	assign adv = !v_s12 || !result_stall;
	assign pop = adv && head_valid;
	assign result_valid = v_s12;
	assign sample = sample_s12;
	assign clamped = clamped_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && wr_s3.query;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// stage 1: grid scaling as two 33x17 partial products per axis
	always_comb begin
		diff_w[0] = $signed(head_item.diff_x);
		diff_w[1] = $signed(head_item.diff_y);
		diff_w[2] = $signed(head_item.diff_z);
		inv_w[0] = cfg.inv_spacing_x;
		inv_w[1] = cfg.inv_spacing_y;
		inv_w[2] = cfg.inv_spacing_z;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pl_s1[i] <= diff_w[i] * $signed({1'b0, inv_w[i][15:0]});
				ph_s1[i] <= diff_w[i] * $signed({1'b0, inv_w[i][31:16]});
			end
			wr_s1.query <= head_item.query;
			wr_s1.voxel_x <= head_item.voxel_x;
			wr_s1.voxel_y <= head_item.voxel_y;
			wr_s1.voxel_z <= head_item.voxel_z;
			wr_s1.voxel_value <= head_item.voxel_value;
		end
	end

	// stage 2: full Q34.32 position
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= (66'(ph_s1[i]) <<< 16) + 66'(pl_s1[i]);
			end
			wr_s2 <= wr_s1;
		end
	end

	// stage 3: cell index, clamp and unclamped fraction
	always_comb begin
		cl_w = 1'b0;
		for (int i = 0; i < 3; i++) begin
			cell_w[i] = $signed(p_s2[i][65:32]);
			u_w[i] = $signed(p_s2[i][65:16]);
			priority if (cell_w[i] < 34'sd0) begin
				c_w[i] = '0;
				cl_w = 1'b1;
			end else if (cell_w[i] > $signed(34'(CELL_MAX[i]))) begin
				c_w[i] = CELL_MAX[i];
				cl_w = 1'b1;
			end else begin
				c_w[i] = p_s2[i][32 +: CW];
			end
			f_w[i] = u_w[i] - $signed(50'(c_w[i]) << 16);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				cell_s3[i] <= c_w[i];
				f_s3[i] <= f_w[i];
			end
			cl_s3 <= cl_w;
			wr_s3 <= wr_s2;
		end
	end

	// eight banks split by the parity of x, y and z: one read per bank per query
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			half_w[i][0] = (cell_s3[i] >> 1) + CW'(cell_s3[i][0]);
			half_w[i][1] = cell_s3[i] >> 1;
		end
	end

	assign wbank_w = {wr_s3.voxel_z[0], wr_s3.voxel_y[0], wr_s3.voxel_x[0]};
	assign waddr_w = {HZW'(wr_s3.voxel_z[5:1]), HYW'(wr_s3.voxel_y[5:1]),
		HXW'(wr_s3.voxel_x[5:1])};
	assign wr_en = adv && v_s3 && (wr_s3.query == OP_WRITE);

	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		localparam int PX = b % 2;
		localparam int PY = (b / 2) % 2;
		localparam int PZ = b / 4;

		assign raddr_w[b] = {HZW'(half_w[2][PZ]), HYW'(half_w[1][PY]), HXW'(half_w[0][PX])};

		tvs_ram #(
			.WIDTH(16),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.we   (wr_en && (wbank_w == 3'(b))),
			.waddr(waddr_w),
			.wdata(wr_s3.voxel_value),
			.re   (adv),
			.raddr(raddr_w[b]),
			.rdata(rd_data[b])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			par_s4 <= {cell_s3[2][0], cell_s3[1][0], cell_s3[0][0]};
			fx_s4 <= f_s3[0];
			fy_s4 <= f_s3[1];
			fz_s4 <= f_s3[2];
			cl_s4 <= cl_s3;
		end
	end

	// stage 5: x lerps, lane j has dy = j[1], dz = j[0]
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			va_w[j] = $signed(rd_data[{par_s4[2] ^ j[0], par_s4[1] ^ j[1], par_s4[0]}]);
			vb_w[j] = $signed(rd_data[{par_s4[2] ^ j[0], par_s4[1] ^ j[1], !par_s4[0]}]);
			d1_w[j] = 17'(vb_w[j]) - 17'(va_w[j]);
		end
		// beyond this the product saturates anyway
		priority if (fx_s4 > FX_HI) begin
			fxl_w = FX_HI[33:0];
		end else if (fx_s4 < FX_LO) begin
			fxl_w = FX_LO[33:0];
		end else begin
			fxl_w = fx_s4[33:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++) begin
				m1_s5[j] <= d1_w[j] * fxl_w;
				va_s5[j] <= va_w[j];
			end
			fy_s5 <= fy_s4;
			fz_s5 <= fz_s4;
			cl_s5 <= cl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++) begin
				c1_s6[j] <= sat32((68'(va_s5[j]) <<< 16) + 68'(m1_s5[j]));
			end
			fy_s6 <= fy_s5;
			fz_s6 <= fz_s5;
			cl_s6 <= cl_s5;
		end
	end

	// y lerps: fraction split into a signed high and unsigned low half
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			d2_w[k] = 33'(c1_s6[2 + k]) - 33'(c1_s6[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 2; k++) begin
				pl2_s7[k] <= d2_w[k] * $signed({1'b0, fy_s6[24:0]});
				ph2_s7[k] <= d2_w[k] * $signed(fy_s6[49:25]);
				a2_s7[k] <= c1_s6[k];
			end
			fz_s7 <= fz_s6;
			cl_s7 <= cl_s6;
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			prod2_w[k] = (83'(ph2_s7[k]) <<< 25) + 83'(pl2_s7[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 2; k++) begin
				x2_s8[k] <= prod2_w[k][82:16];
				a2_s8[k] <= a2_s7[k];
			end
			fz_s8 <= fz_s7;
			cl_s8 <= cl_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 2; k++) begin
				c2_s9[k] <= sat32(68'(a2_s8[k]) + 68'(x2_s8[k]));
			end
			fz_s9 <= fz_s8;
			cl_s9 <= cl_s8;
		end
	end

	// z lerp
	assign d3_w = 33'(c2_s9[1]) - 33'(c2_s9[0]);
	assign prod3_w = (83'(ph3_s10) <<< 25) + 83'(pl3_s10);

	always_ff @(posedge clk) begin
		if (adv) begin
			pl3_s10 <= d3_w * $signed({1'b0, fz_s9[24:0]});
			ph3_s10 <= d3_w * $signed(fz_s9[49:25]);
			a3_s10 <= c2_s9[0];
			cl_s10 <= cl_s9;
			x3_s11 <= prod3_w[82:16];
			a3_s11 <= a3_s10;
			cl_s11 <= cl_s10;
			sample_s12 <= sat32(68'(a3_s11) + 68'(x3_s11));
			clamped_s12 <= cl_s11;
		end
	end

endmodule

### rtl/core/trilinear_volume_sampler_unit.sv
// Trilinear volume sampler. Items are voxel writes (opcode 0) or point queries
// (opcode 1); each query returns one beat with the saturated Q16.16 sample and a
// clamped flag, writes return nothing. One item is taken every cycle while the
// 4-entry input queue has room; query results come back in input order. The rate
// is set by the volume memory: it is split into eight banks by the parity of x, y
// and z (32768 x 16 each at 64^3), so all eight neighbours of a cell are read in
// the same cycle, and writes use the same single write port of a bank in item
// order. The volume has no reset and no clearing pass: a voxel reads undefined
// until it has been written. The user must write configuration registers only
// while idle; the block itself does not enforce this.
module trilinear_volume_sampler_unit import tvs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              opcode,
	input  logic [5:0]        voxel_x,
	input  logic [5:0]        voxel_y,
	input  logic [5:0]        voxel_z,
	input  logic signed [15:0] voxel_value,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic signed [31:0] query_z,
	output logic              result_valid,
	input  logic              result_stall,
	output logic signed [31:0] sample,
	output logic              clamped
);

	tvs_cfg_t  cfg_q;
	logic      q_full;
	logic      push;
	tvs_item_t push_item;
	logic      pop;
	logic      head_valid;
	tvs_item_t head_item;
	logic      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.inv_spacing_x <= INV_SPACING_RESET;
			cfg_q.inv_spacing_y <= INV_SPACING_RESET;
			cfg_q.inv_spacing_z <= INV_SPACING_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[CFG_AW-1:2])
				REG_ORIGIN_X: cfg_q.origin_x <= pwdata;
				REG_ORIGIN_Y: cfg_q.origin_y <= pwdata;
				REG_ORIGIN_Z: cfg_q.origin_z <= pwdata;
				REG_INV_SPACING_X: cfg_q.inv_spacing_x <= pwdata;
				REG_INV_SPACING_Y: cfg_q.inv_spacing_y <= pwdata;
				REG_INV_SPACING_Z: cfg_q.inv_spacing_z <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[CFG_AW-1:2])
			REG_ORIGIN_X: prdata = cfg_q.origin_x;
			REG_ORIGIN_Y: prdata = cfg_q.origin_y;
			REG_ORIGIN_Z: prdata = cfg_q.origin_z;
			REG_INV_SPACING_X: prdata = cfg_q.inv_spacing_x;
			REG_INV_SPACING_Y: prdata = cfg_q.inv_spacing_y;
			REG_INV_SPACING_Z: prdata = cfg_q.inv_spacing_z;
			default: prdata = '0;
		endcase
	end

	tvs_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.opcode     (opcode),
		.voxel_x    (voxel_x),
		.voxel_y    (voxel_y),
		.voxel_z    (voxel_z),
		.voxel_value(voxel_value),
		.query_x    (query_x),
		.query_y    (query_y),
		.query_z    (query_z),
		.cfg        (cfg_q),
		.q_full     (q_full),
		.push       (push),
		.item       (push_item)
	);

	tvs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	tvs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sample      (sample),
		.clamped     (clamped)
	);

endmodule

### rtl/core/tvs_checker.sv
module tvs_checker import tvs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [CFG_AW-1:0] paddr,
	input logic [31:0]       pwdata,
	input logic [31:0]       prdata,
	input logic              pready,
	input logic              item_valid,
	input logic              item_stall,
	input logic              opcode,
	input logic [5:0]        voxel_x,
	input logic [5:0]        voxel_y,
	input logic [5:0]        voxel_z,
	input logic [15:0]       voxel_value,
	input logic [31:0]       query_x,
	input logic [31:0]       query_y,
	input logic [31:0]       query_z,
	input logic              result_valid,
	input logic              result_stall,
	input logic [31:0]       sample,
	input logic              clamped
);

	// nothing comes out of reset
	a_reset_quiet: assert property (@(posedge clk) $rose(arst_n) |-> !result_valid)
		else $error("result beat right after reset");

	// the queue only fills up on an accepted beat
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(item_valid && !item_stall))
		else $error("input stall rose without an accepted beat");

	// a written register reads back on the next cycle
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $past(psel && penable && pwrite && pready)
			&& $past(paddr[4:2]) != 3'd6 && $past(paddr[4:2]) != 3'd7
			&& paddr[4:2] == $past(paddr[4:2])) |-> prdata == $past(pwdata))
		else $error("configuration readback mismatch");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(sample) && $stable(clamped))
		else $error("stalled result beat changed");

endmodule

bind trilinear_volume_sampler_unit tvs_checker u_tvs_checker (.*);
